// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, reset masked.
`define BCM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, reset masked.
`define BCM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== rtl/bcm_pkg.sv =====
// Package: constants, codes and state type of the binomial mod prime block.
package bcm_pkg;
   localparam int          TABLE_SIZE = 4096;
   localparam int          ADDR_W     = $clog2(TABLE_SIZE);
   localparam int          ARG_W      = 12;
   localparam int          VAL_W      = 30;
   localparam logic [29:0] PRIME      = 30'd1000000007;

   typedef enum logic [0:0] {
      OP_BUILD = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NOT_BUILT  = 2'd1,
      STATUS_BUILD_DONE = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_INIT0, ST_INIT1, ST_DIV, ST_RDINV, ST_MULFAC, ST_MULINV,
      ST_MULFINV, ST_WRITE, ST_QRD0, ST_QRD1, ST_QRD2, ST_QMUL0, ST_QMUL1,
      ST_DONE
   } state_type;
endpackage

// ===== rtl/binomial_coefficient_mod_prime.sv =====
// Top level: n choose k modulo 1000000007 from factorial and inverse tables.
// Query: from accepted beat to result, three table reads and two 30-step shift-add
//   modular multiplies; refused or k > n queries go straight to the result.
// Build: per entry a 30-step divider plus three multiplies, for all 4096 entries;
//   one item at a time, the next beat taken in the cycle after the result is
//   loaded, later while a stalled result blocks.
module binomial_coefficient_mod_prime (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [0:0]                  req_op,
   input  logic [bcm_pkg::ARG_W-1:0]   req_n_value,
   input  logic [bcm_pkg::ARG_W-1:0]   req_k_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bcm_pkg::VAL_W-1:0]   rsp_value,
   output logic [1:0]                  rsp_status
);
   import bcm_pkg::*;

   // Table storage: one write port, one registered read port each.
   logic [VAL_W-1:0] fac_mem  [TABLE_SIZE];
   logic [VAL_W-1:0] inv_mem  [TABLE_SIZE];
   logic [VAL_W-1:0] finv_mem [TABLE_SIZE];
   logic [VAL_W-1:0] fac_rd_ff, inv_rd_ff, finv_rd_ff;

   state_type        state_ff, state_in;
   logic             built_ff, built_in;
   logic [ADDR_W-1:0] i_ff, i_in;            // build index
   logic [ADDR_W-1:0] rem_ff, rem_in;        // divider remainder, later P mod i
   logic [29:0]      quo_ff, quo_in;         // divider quotient, P / i
   logic [4:0]       cnt_ff, cnt_in;         // step count of the shared units
   logic [29:0]      ma_ff, ma_in;           // multiplier, MSB first
   logic [29:0]      mb_ff, mb_in;           // multiplicand
   logic [29:0]      acc_ff, acc_in;         // running product mod P
   logic [29:0]      fprev_ff, fprev_in;     // fac[i-1], or fac[n] on query
   logic [29:0]      iprev_ff, iprev_in;     // finv[i-1], or finv[k] on query
   logic [29:0]      fac_i_ff, fac_i_in;
   logic [29:0]      inv_i_ff, inv_i_in;
   logic [ARG_W-1:0] n_ff, n_in, k_ff, k_in;
   logic [29:0]      res_ff, res_in;
   status_type       rst_ff, rst_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [29:0]      rsp_value_ff, rsp_value_in;
   status_type       rsp_status_ff, rsp_status_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [29:0]       wr_fac, wr_inv, wr_finv;
   logic [ADDR_W-1:0] fac_ra, finv_ra;

   logic [29:0]       mstep;
   logic              mlast;
   logic [ADDR_W:0]   dshift;
   logic              dge;
   logic [ADDR_W-1:0] dnext;

   // One shift-add step of the modular multiply: acc = 2*acc + bit*b mod P.
   function automatic logic [29:0] mm_step(input logic [29:0] acc,
                                           input logic [29:0] b,
                                           input logic        bt);
      logic [30:0] d;
      logic [30:0] s;
      d = {acc, 1'b0};
      if (d >= {1'b0, PRIME}) d = d - {1'b0, PRIME};
      s = d + (bt ? {1'b0, b} : 31'd0);
      if (s >= {1'b0, PRIME}) s = s - {1'b0, PRIME};
      return s[29:0];
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fac_mem[wr_addr]  <= wr_fac;
         inv_mem[wr_addr]  <= wr_inv;
         finv_mem[wr_addr] <= wr_finv;
      end
      fac_rd_ff  <= fac_mem[fac_ra];
      inv_rd_ff  <= inv_mem[rem_ff];
      finv_rd_ff <= finv_mem[finv_ra];
   end

   // Shared unit datapaths
   assign mstep = mm_step(acc_ff, mb_ff, ma_ff[29]);
   assign mlast = (cnt_ff == 5'd29);
   // restoring division of the constant P by i, one dividend bit a step
   assign dshift = {rem_ff, PRIME[5'd29 - cnt_ff]};
   assign dge    = (dshift >= {1'b0, i_ff});
   assign dnext  = dge ? ADDR_W'(dshift - {1'b0, i_ff}) : dshift[ADDR_W-1:0];

   assign fac_ra  = ADDR_W'(n_ff);
   assign finv_ra = (state_ff == ST_QRD0) ? ADDR_W'(k_ff) : ADDR_W'(n_ff - k_ff);

   always_comb begin
      state_in      = state_ff;
      built_in      = built_ff;
      i_in          = i_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      ma_in         = ma_ff;
      mb_in         = mb_ff;
      acc_in        = acc_ff;
      fprev_in      = fprev_ff;
      iprev_in      = iprev_ff;
      fac_i_in      = fac_i_ff;
      inv_i_in      = inv_i_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      res_in        = res_ff;
      rst_in        = rst_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = i_ff;
      wr_fac        = fac_i_ff;
      wr_inv        = inv_i_ff;
      wr_finv       = iprev_ff;
      req_stall     = (state_ff != ST_IDLE);

      // advance the multiply in any multiply state
      if (state_ff inside {ST_MULFAC, ST_MULINV, ST_MULFINV, ST_QMUL0, ST_QMUL1}) begin
         acc_in = mstep;
         ma_in  = {ma_ff[28:0], 1'b0};
         cnt_in = cnt_ff + 5'd1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               n_in   = req_n_value;
               k_in   = req_k_value;
               res_in = '0;
               if (req_op == OP_BUILD) begin
                  state_in = ST_INIT0;
               end else if (!built_ff) begin
                  rst_in   = STATUS_NOT_BUILT;
                  state_in = ST_DONE;
               end else if (req_k_value > req_n_value ||
                            32'(req_n_value) >= TABLE_SIZE) begin
                  rst_in   = STATUS_OK;
                  state_in = ST_DONE;
               end else begin
                  rst_in   = STATUS_OK;
                  state_in = ST_QRD0;
               end
            end
         end
         ST_INIT0: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_fac   = 30'd1;
            wr_inv   = 30'd0;
            wr_finv  = 30'd1;
            state_in = ST_INIT1;
         end
         ST_INIT1: begin
            wr_en    = 1'b1;
            wr_addr  = ADDR_W'(1);
            wr_fac   = 30'd1;
            wr_inv   = 30'd1;
            wr_finv  = 30'd1;
            i_in     = ADDR_W'(2);
            rem_in   = '0;
            quo_in   = '0;
            cnt_in   = '0;
            fprev_in = 30'd1;
            iprev_in = 30'd1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = dnext;
            quo_in = {quo_ff[28:0], dge};
            cnt_in = cnt_ff + 5'd1;
            if (mlast) state_in = ST_RDINV;
         end
         ST_RDINV: begin
            // inv[P mod i] is read this cycle; meanwhile start fac[i-1] * i
            ma_in    = fprev_ff;
            mb_in    = {{(30-ADDR_W){1'b0}}, i_ff};
            acc_in   = '0;
            cnt_in   = '0;
            state_in = ST_MULFAC;
         end
         ST_MULFAC: begin
            if (mlast) begin
               fac_i_in = mstep;
               ma_in    = inv_rd_ff;
               mb_in    = quo_ff;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_MULINV;
            end
         end
         ST_MULINV: begin
            if (mlast) begin
               inv_i_in = PRIME - mstep;
               ma_in    = iprev_ff;
               mb_in    = PRIME - mstep;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_MULFINV;
            end
         end
         ST_MULFINV: begin
            if (mlast) begin
               iprev_in = mstep;
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_en    = 1'b1;
            fprev_in = fac_i_ff;
            if (i_ff == ADDR_W'(TABLE_SIZE - 1)) begin
               built_in = 1'b1;
               rst_in   = STATUS_BUILD_DONE;
               state_in = ST_DONE;
            end else begin
               i_in     = i_ff + ADDR_W'(1);
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_QRD0: state_in = ST_QRD1;
         ST_QRD1: begin
            iprev_in = finv_rd_ff;   // finv[k]
            state_in = ST_QRD2;
         end
         ST_QRD2: begin
            fprev_in = fac_rd_ff;    // fac[n]
            ma_in    = iprev_ff;
            mb_in    = finv_rd_ff;   // finv[n-k]
            acc_in   = '0;
            cnt_in   = '0;
            state_in = ST_QMUL0;
         end
         ST_QMUL0: begin
            if (mlast) begin
               ma_in    = fprev_ff;
               mb_in    = mstep;
               acc_in   = '0;
               cnt_in   = '0;
               state_in = ST_QMUL1;
            end
         end
         ST_QMUL1: begin
            if (mlast) begin
               res_in   = mstep;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_ff;
               rsp_status_in = rst_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff          <= i_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      ma_ff         <= ma_in;
      mb_ff         <= mb_in;
      acc_ff        <= acc_in;
      fprev_ff      <= fprev_in;
      iprev_ff      <= iprev_in;
      fac_i_ff      <= fac_i_in;
      inv_i_ff      <= inv_i_in;
      n_ff          <= n_in;
      k_ff          <= k_in;
      res_ff        <= res_in;
      rst_ff        <= rst_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
endmodule

// ===== rtl/bcm_checker.sv =====
// Port checker for the binomial mod prime block, bound to the top level.
`include "assert_macros.svh"
module bcm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic [0:0]                req_op,
   input logic [bcm_pkg::ARG_W-1:0] req_n_value,
   input logic [bcm_pkg::ARG_W-1:0] req_k_value,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [bcm_pkg::VAL_W-1:0] rsp_value,
   input logic [1:0]                rsp_status
);
   import bcm_pkg::*;

   `BCM_ASSERT_IMP(a_nonok_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_value == '0)
   `BCM_ASSERT_IMP(a_value_range, clock, reset, rsp_valid, rsp_value < PRIME && rsp_status != 2'd3)
   `BCM_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `BCM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_value))
endmodule

bind binomial_coefficient_mod_prime bcm_checker u_bcm_checker (.*);

// ===== verif/tb_binomial_coefficient_mod_prime.sv =====
// Testbench for the binomial coefficient mod prime block: directed table, then random queries.
`timescale 1ns / 100ps

module tb_binomial_coefficient_mod_prime;
   import bcm_pkg::*;

   localparam longint unsigned MODULUS = 64'd1000000007;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [0:0]         req_op;
   logic [ARG_W-1:0]   req_n_value;
   logic [ARG_W-1:0]   req_k_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [VAL_W-1:0]   rsp_value;
   logic [1:0]         rsp_status;

   binomial_coefficient_mod_prime dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_n_value (req_n_value),
      .req_k_value (req_k_value),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_value   (rsp_value),
      .rsp_status  (rsp_status)
   );

   // Free-running clock, 20 ns period.
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Own copy of the block's tables; filled in one go when a build beat is accepted.
   longint unsigned fact_tab [TABLE_SIZE];
   longint unsigned inv_tab  [TABLE_SIZE];
   longint unsigned ifact_tab[TABLE_SIZE];
   bit              tabs_ready;

   // Expected results, oldest first.
   logic [VAL_W-1:0] want_value [$];
   status_type       want_status[$];

   int  mismatches;
   bit  no_idle;        // stretch with no idling on either side
   bit  hold_request;   // ask the receiver for one long hold-off

   function automatic longint unsigned mul_mod_p(longint unsigned a, longint unsigned b);
      return (a * b) % MODULUS;
   endfunction

   task automatic fill_tables();
      longint unsigned r;
      longint unsigned q;
      fact_tab[0] = 1; ifact_tab[0] = 1; inv_tab[0] = 0;
      fact_tab[1] = 1; ifact_tab[1] = 1; inv_tab[1] = 1;
      for (int i = 2; i < TABLE_SIZE; i++) begin
         r = MODULUS % i;
         q = MODULUS / i;
         fact_tab[i]  = mul_mod_p(fact_tab[i-1], i);
         inv_tab[i]   = MODULUS - mul_mod_p(inv_tab[r], q);
         ifact_tab[i] = mul_mod_p(ifact_tab[i-1], inv_tab[i]);
      end
      tabs_ready = 1'b1;
   endtask

   // Work out the result of one accepted beat and queue it.
   task automatic predict_binomial(op_type op, int unsigned n, int unsigned k);
      longint unsigned v;
      status_type      st;
      v  = 0;
      st = STATUS_OK;
      if (op == OP_BUILD) begin
         fill_tables();
         st = STATUS_BUILD_DONE;
      end else if (!tabs_ready) begin
         st = STATUS_NOT_BUILT;
      end else if (k <= n && n < TABLE_SIZE) begin
         v = mul_mod_p(fact_tab[n], mul_mod_p(ifact_tab[k], ifact_tab[n-k]));
      end
      want_value.push_back(v[VAL_W-1:0]);
      want_status.push_back(st);
   endtask

   // Draw an idle gap: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      if (no_idle) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
      return $urandom_range(10, 40);
   endfunction

   // Offer one beat, hold it until accepted, then queue the expected result.
   // With a typed expectation the queued result is the typed one, not the predictor's.
   task automatic send_beat(op_type op, int unsigned n, int unsigned k,
                            bit typed, logic [VAL_W-1:0] tv, status_type ts);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_op      <= op;
      req_n_value <= n[ARG_W-1:0];
      req_k_value <= k[ARG_W-1:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_binomial(op, n, k);
      if (typed) begin
         want_value[$]  = tv;
         want_status[$] = ts;
      end
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Directed table: opening extremes, build, special cases, repeated build.
   typedef struct {
      op_type           op;
      int unsigned      n;
      int unsigned      k;
      bit               typed;
      logic [VAL_W-1:0] value;
      status_type       status;
   } stim_row_type;

   stim_row_type directed[] = '{
      '{OP_QUERY,    0,    0, 1, 30'd0,       STATUS_NOT_BUILT},
      '{OP_QUERY, 4095, 4095, 1, 30'd0,       STATUS_NOT_BUILT},
      '{OP_BUILD,    0,    0, 1, 30'd0,       STATUS_BUILD_DONE},
      '{OP_QUERY,    0,    0, 1, 30'd1,       STATUS_OK},
      '{OP_QUERY,    0, 4095, 1, 30'd0,       STATUS_OK},
      '{OP_QUERY,    1,    2, 1, 30'd0,       STATUS_OK},
      '{OP_QUERY, 4095,    0, 1, 30'd1,       STATUS_OK},
      '{OP_QUERY, 4095, 4095, 1, 30'd1,       STATUS_OK},
      '{OP_QUERY, 4095,    1, 1, 30'd4095,    STATUS_OK},
      '{OP_QUERY, 4095, 4094, 1, 30'd4095,    STATUS_OK},
      '{OP_QUERY, 4095,    2, 1, 30'd8382465, STATUS_OK},
      '{OP_QUERY,    5,    2, 1, 30'd10,      STATUS_OK},
      '{OP_QUERY, 4094, 4095, 1, 30'd0,       STATUS_OK},
      '{OP_QUERY, 4095, 2047, 0, 30'd0,       STATUS_OK},
      '{OP_QUERY, 2730, 1365, 0, 30'd0,       STATUS_OK},
      '{OP_QUERY, 1365, 1000, 0, 30'd0,       STATUS_OK},
      '{OP_QUERY,   64,   32, 0, 30'd0,       STATUS_OK},
      // Repeated build: same tables, still answers a build-done beat.
      '{OP_BUILD, 4095, 4095, 1, 30'd0,       STATUS_BUILD_DONE},
      '{OP_QUERY, 4095, 2048, 0, 30'd0,       STATUS_OK},
      '{OP_QUERY,  100,   37, 0, 30'd0,       STATUS_OK}
   };

   // Receiver: random stalls, a no-stall stretch when asked, one long hold-off on request.
   initial begin
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            // Hold off long enough that the block backs up and stalls its input.
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (no_idle) begin
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 99) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 9) < 3) ? 1'b1 :
                         ($urandom_range(0, 49) == 0 ? 1'b1 : 1'b0);
         end
      end
   end

   // Result checker: compare each accepted beat with the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (want_value.size() == 0) begin
            $error("unexpected result beat: value %0d status %0d", rsp_value, rsp_status);
            mismatches++;
         end else begin
            if (rsp_value !== want_value[0]) begin
               $error("value: expected %0d, got %0d", want_value[0], rsp_value);
               mismatches++;
            end
            if (rsp_status !== want_status[0]) begin
               $error("status: expected %0d, got %0d", want_status[0], rsp_status);
               mismatches++;
            end
            void'(want_value.pop_front());
            void'(want_status.pop_front());
         end
      end
   end

   // Stimulus.
   initial begin
      int unsigned n;
      int unsigned k;
      int unsigned drain;
      mismatches   = 0;
      tabs_ready   = 1'b0;
      no_idle      = 1'b0;
      hold_request = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_op       = OP_QUERY;
      req_n_value  = '0;
      req_k_value  = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_beat(directed[i].op, directed[i].n, directed[i].k,
                   directed[i].typed, directed[i].value, directed[i].status);

      // Sender pause: let every outstanding result drain before going on.
      req_valid <= 1'b0;
      while (want_value.size() != 0) @(posedge clock);
      @(posedge clock);

      // Random queries; a build walks all 4096 table entries, so builds stay in the table.
      for (int i = 0; i < 450; i++) begin
         no_idle = ((i / 60) % 3 == 2);
         if (i == 100) hold_request = 1'b1;
         case ($urandom_range(0, 9))
            0:       n = $urandom_range(0, 15);
            1:       n = 4095 - $urandom_range(0, 15);
            default: n = $urandom_range(0, 4095);
         endcase
         if ($urandom_range(0, 9) < 8) k = $urandom_range(0, n);
         else k = $urandom_range(0, 4095);
         send_beat(OP_QUERY, n, k, 1'b0, '0, STATUS_OK);
      end
      req_valid <= 1'b0;

      drain = 0;
      while (want_value.size() != 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (200) @(posedge clock);

      if (mismatches == 0 && want_value.size() == 0)
         $display("tb_binomial_coefficient_mod_prime: PASS");
      else
         $display("tb_binomial_coefficient_mod_prime: FAIL");
      $finish;
   end

   // Watchdog: two builds plus all queries, with a wide margin.
   initial begin
      #(64'd200_000_000);
      $display("tb_binomial_coefficient_mod_prime: FAIL");
      $finish;
   end

endmodule
